// File: rtl/core/tiered_pool_table_round_robin_top_macros.svh
// ----------------------------------------------------------------------------
// Tiered pool table assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TIERED_POOL_TABLE_ROUND_ROBIN_TOP_MACROS_SVH
`define TIERED_POOL_TABLE_ROUND_ROBIN_TOP_MACROS_SVH

// plain property
`define TPTRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define TPTRR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TPTRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/tptrr_pkg.sv
// ----------------------------------------------------------------------------
// tptrr_pkg
// Types, codes and constants shared by the tiered pool table blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package tptrr_pkg;

  localparam int unsigned DEF_TARGET_SLOTS = 256;
  localparam int unsigned DEF_MAX_PICKS    = 64;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned TARGET_W = 8;
  localparam int unsigned NODE_W   = 16;
  localparam int unsigned POOL_W   = 2;
  localparam int unsigned PICK_W   = 7;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 16;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_ADD_UPDATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_ABSENT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CHOOSE     = 3'd4;

  // pool codes
  localparam logic [POOL_W-1:0] POOL_NORMAL = 2'd0;
  localparam logic [POOL_W-1:0] POOL_LOW    = 2'd1;
  localparam logic [POOL_W-1:0] POOL_EMERG  = 2'd2;
  localparam logic [POOL_W-1:0] POOL_NONE   = 2'd3;

  typedef struct packed {
    logic [POOL_W-1:0] pool;
    logic [NODE_W-1:0] node;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [TARGET_W-1:0] target_id;
    logic [NODE_W-1:0]   node_id;
    logic [POOL_W-1:0]   pool_kind;
    logic [PICK_W-1:0]   want_count;
  } req_t;

  typedef struct packed {
    logic                changed;
    logic                found;
    logic [POOL_W-1:0]   pool_of_target;
    logic [TARGET_W-1:0] chosen_target;
    logic                chosen_valid;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/tptrr_ram.sv
// ----------------------------------------------------------------------------
// tptrr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tptrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tptrr_out.sv
// ----------------------------------------------------------------------------
// tptrr_out
// Result register between the controller and the master stream port.
// ----------------------------------------------------------------------------
`default_nettype none

module tptrr_out (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push_i,
  input  wire tptrr_pkg::res_t                     res_i,
  output logic                                     free_o,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // changed, found, pool_of_target[1:0], chosen_target[7:0], zero pad
  output logic [tptrr_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  // chosen_valid
  output logic                                     m_axis_tuser,
  output logic                                     m_axis_tlast
);

  logic            vld_q;
  tptrr_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (push_i) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign free_o        = !vld_q || m_axis_tready;
  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {4'd0, res_q.chosen_target, res_q.pool_of_target,
                          res_q.found, res_q.changed};
  assign m_axis_tuser  = res_q.chosen_valid;
  assign m_axis_tlast  = res_q.last;

endmodule

`default_nettype wire

// File: rtl/core/tptrr_ctrl.sv
// ----------------------------------------------------------------------------
// tptrr_ctrl
// Request sequencer: slot table read-modify-write, pool size tallies and the
// round-robin walk over the slot memory.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tiered_pool_table_round_robin_top_macros.svh"

module tptrr_ctrl #(
  parameter int unsigned TARGET_SLOTS = tptrr_pkg::DEF_TARGET_SLOTS,
  parameter int unsigned MAX_PICKS    = tptrr_pkg::DEF_MAX_PICKS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            req_valid_i,
  output logic                                 req_ready_o,
  input  wire tptrr_pkg::req_t                 req_i,
  output logic                                 rd_en_o,
  output logic [$clog2(TARGET_SLOTS)-1:0]      rd_addr_o,
  input  wire tptrr_pkg::slot_t                rd_data_i,
  output logic                                 wr_en_o,
  output logic [$clog2(TARGET_SLOTS)-1:0]      wr_addr_o,
  output tptrr_pkg::slot_t                     wr_data_o,
  output logic                                 res_push_o,
  output tptrr_pkg::res_t                      res_o,
  input  wire logic                            res_free_i
);

  localparam int unsigned IDX_W = $clog2(TARGET_SLOTS);
  localparam int unsigned CNT_W = $clog2(TARGET_SLOTS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TARGET_SLOTS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_TBL   = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] x);
    ring_inc = (x == IDX_LAST) ? '0 : x + 1'b1;
  endfunction

  logic [1:0]                  state_q, state_d;
  logic [IDX_W-1:0]            clr_q, clr_d;
  logic [CNT_W-1:0]            sizes_q [3];
  logic [CNT_W-1:0]            sizes_d [3];
  logic [IDX_W-1:0]            last_q, last_d;
  logic                        rd_vld_q, rd_vld_d;
  logic                        phase_q, phase_d;   // 0: seeking start, 1: picking
  logic [tptrr_pkg::PICK_W-1:0] cnt_q, cnt_d;
  logic [tptrr_pkg::PICK_W-1:0] n_q, n_d;
  logic [IDX_W-1:0]            ptr_q, ptr_d;
  logic [IDX_W-1:0]            rd_addr_q, rd_addr_d;
  logic [tptrr_pkg::REQ_W-1:0]  op_q, op_d;
  logic                        ok_q, ok_d;
  logic [tptrr_pkg::NODE_W-1:0] node_q, node_d;
  logic [tptrr_pkg::POOL_W-1:0] pk_q, pk_d;
  logic [tptrr_pkg::POOL_W-1:0] psel_q, psel_d;

  logic                        accept;
  logic                        any_pool;
  logic [tptrr_pkg::POOL_W-1:0] tier;
  logic [CNT_W-1:0]            tier_size;
  logic [tptrr_pkg::PICK_W-1:0] n_cap;
  logic [tptrr_pkg::POOL_W-1:0] cur_pool;
  logic                        in_pool;
  logic [tptrr_pkg::POOL_W-1:0] dest_pool;
  logic [2:0]                  inc, dec;
  logic                        scan_hit, scan_emit, scan_stall, scan_fin;
  logic                        wr_en;
  logic                        res_push;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  // first non-empty tier and the capped pick count
  always_comb begin
    any_pool = (sizes_q[0] != '0) || (sizes_q[1] != '0) || (sizes_q[2] != '0);
    if (sizes_q[0] != '0) begin
      tier      = tptrr_pkg::POOL_NORMAL;
      tier_size = sizes_q[0];
    end else if (sizes_q[1] != '0) begin
      tier      = tptrr_pkg::POOL_LOW;
      tier_size = sizes_q[1];
    end else begin
      tier      = tptrr_pkg::POOL_EMERG;
      tier_size = sizes_q[2];
    end
    if (32'(req_i.want_count) <= 32'(tier_size)) begin
      n_cap = req_i.want_count;
    end else begin
      n_cap = tptrr_pkg::PICK_W'(tier_size);
    end
    if (32'(n_cap) > 32'(MAX_PICKS)) begin
      n_cap = tptrr_pkg::PICK_W'(MAX_PICKS);
    end
  end

  assign cur_pool = rd_data_i.pool;
  assign in_pool  = (cur_pool != tptrr_pkg::POOL_NONE);
  assign dest_pool = (op_q == tptrr_pkg::REQ_ADD_ABSENT && in_pool) ? cur_pool : pk_q;

  assign scan_hit   = rd_vld_q && (cur_pool == psel_q);
  assign scan_emit  = scan_hit && (phase_q || (n_q == '0));
  assign scan_stall = scan_emit && !res_free_i;
  assign scan_fin   = scan_emit && res_free_i &&
                      (!phase_q || (tptrr_pkg::PICK_W'(cnt_q + 1'b1) == n_q));

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    last_d    = last_q;
    rd_vld_d  = rd_vld_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    ptr_d     = ptr_q;
    rd_addr_d = rd_addr_q;
    op_d      = op_q;
    ok_d      = ok_q;
    node_d    = node_q;
    pk_d      = pk_q;
    psel_d    = psel_q;
    rd_en_o   = 1'b0;
    rd_addr_o = ptr_q;
    wr_en     = 1'b0;
    wr_addr_o = rd_addr_q;
    wr_data_o = '0;
    res_push  = 1'b0;
    res_o     = '0;
    inc       = '0;
    dec       = '0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en          = 1'b1;
        wr_addr_o      = clr_q;
        wr_data_o.pool = tptrr_pkg::POOL_NONE;
        wr_data_o.node = '0;
        if (clr_q == IDX_LAST) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_d    = req_i.req_type;
          ok_d    = 32'(req_i.target_id) < 32'(TARGET_SLOTS);
          node_d  = req_i.node_id;
          pk_d    = (req_i.pool_kind == tptrr_pkg::POOL_NONE) ? tptrr_pkg::POOL_EMERG
                                                              : req_i.pool_kind;
          rd_en_o = 1'b1;
          if (req_i.req_type == tptrr_pkg::REQ_CHOOSE && any_pool) begin
            rd_addr_o = last_q;
            rd_addr_d = last_q;
            ptr_d     = ring_inc(last_q);
            rd_vld_d  = 1'b1;
            phase_d   = 1'b0;
            cnt_d     = '0;
            n_d       = n_cap;
            psel_d    = tier;
            state_d   = ST_SCAN;
          end else begin
            // choose with every pool empty lands in the null result path
            rd_addr_o = IDX_W'(req_i.target_id);
            rd_addr_d = IDX_W'(req_i.target_id);
            rd_vld_d  = 1'b0;
            state_d   = ST_TBL;
          end
        end
      end

      ST_TBL: begin
        if (res_free_i) begin
          res_push   = 1'b1;
          res_o.last = 1'b1;
          state_d    = ST_IDLE;
          case (op_q) inside
            tptrr_pkg::REQ_ADD_UPDATE, tptrr_pkg::REQ_ADD_ABSENT: begin
              if (ok_q) begin
                res_o.changed  = !(cur_pool == dest_pool && rd_data_i.node == node_q);
                wr_en          = 1'b1;
                wr_data_o.pool = dest_pool;
                wr_data_o.node = node_q;
                if (cur_pool != dest_pool) begin
                  for (int k = 0; k < 3; k++) begin
                    inc[k] = (dest_pool == tptrr_pkg::POOL_W'(k));
                    dec[k] = (cur_pool == tptrr_pkg::POOL_W'(k));
                  end
                end
              end
            end
            tptrr_pkg::REQ_REMOVE: begin
              if (ok_q && in_pool) begin
                wr_en          = 1'b1;
                wr_data_o.pool = tptrr_pkg::POOL_NONE;
                wr_data_o.node = rd_data_i.node;
                for (int k = 0; k < 3; k++) begin
                  dec[k] = (cur_pool == tptrr_pkg::POOL_W'(k));
                end
              end
            end
            tptrr_pkg::REQ_QUERY: begin
              res_o.found          = ok_q && in_pool;
              res_o.pool_of_target = (ok_q && in_pool) ? cur_pool : tptrr_pkg::POOL_EMERG;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_emit && res_free_i) begin
          res_push = 1'b1;
          if (phase_q) begin
            res_o.chosen_target = tptrr_pkg::TARGET_W'(rd_addr_q);
            res_o.chosen_valid  = 1'b1;
            res_o.last          = scan_fin;
            cnt_d               = cnt_q + 1'b1;
          end else begin
            res_o.last = 1'b1;
          end
        end
        if (scan_hit && !phase_q && n_q != '0) begin
          phase_d = 1'b1;
        end
        if (scan_fin) begin
          last_d   = rd_addr_q;
          rd_vld_d = 1'b0;
          state_d  = ST_IDLE;
        end else if (!scan_stall) begin
          // one slot per cycle; a stalled pick keeps the RAM output in place
          rd_en_o   = 1'b1;
          rd_addr_o = ptr_q;
          rd_addr_d = ptr_q;
          ptr_d     = ring_inc(ptr_q);
          rd_vld_d  = 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    for (int k = 0; k < 3; k++) begin
      sizes_d[k] = sizes_q[k];
      if (inc[k] && !dec[k]) begin
        sizes_d[k] = sizes_q[k] + 1'b1;
      end else if (dec[k] && !inc[k] && sizes_q[k] != '0) begin
        sizes_d[k] = sizes_q[k] - 1'b1;
      end
    end
  end

  assign wr_en_o    = wr_en;
  assign res_push_o = res_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      last_q   <= '0;
      rd_vld_q <= 1'b0;
      phase_q  <= 1'b0;
      cnt_q    <= '0;
      for (int k = 0; k < 3; k++) begin
        sizes_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      last_q   <= last_d;
      rd_vld_q <= rd_vld_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      for (int k = 0; k < 3; k++) begin
        sizes_q[k] <= sizes_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    ptr_q     <= ptr_d;
    rd_addr_q <= rd_addr_d;
    op_q      <= op_d;
    ok_q      <= ok_d;
    node_q    <= node_d;
    pk_q      <= pk_d;
    psel_q    <= psel_d;
  end

  `TPTRR_ASSERT(a_size_bound, (32'(sizes_q[0]) + 32'(sizes_q[1]) + 32'(sizes_q[2])) <= 32'(TARGET_SLOTS), "pool sizes exceed slot count")
  `TPTRR_ASSERT_IMPL(a_push_state, res_push, (state_q == ST_TBL) || (state_q == ST_SCAN), "result pushed outside a request")
  `TPTRR_ASSERT_IMPL(a_pick_count, (state_q == ST_SCAN) && phase_q, cnt_q < n_q, "pick count overran")
  `TPTRR_ASSERT_IMPL(a_no_write_scan, state_q == ST_SCAN, !wr_en, "table written during walk")
  `TPTRR_ASSERT_NEXT(a_stall_hold, (state_q == ST_SCAN) && scan_stall, $stable(rd_addr_q) && $stable(cnt_q), "stalled walk moved")

endmodule

`default_nettype wire

// File: rtl/core/tiered_pool_table_round_robin_top.sv
// Table requests: a registered slot read, then the result enters the output register
// when it is free; one slot read-modify-write each, and the next request waits for it.
// Choose walks the slot memory one entry per cycle through its read port, a start search
//   and then at most one lap of picks, and pauses while the output stalls.
// Reset: control state clears at once, then a sweep marks every slot in turn
//   as in no pool with node 0; s_axis_tready stays low during the sweep.
// ----------------------------------------------------------------------------
// tiered_pool_table_round_robin_top
// Slot table with normal/low/emergency pools and a round-robin chooser.
// ----------------------------------------------------------------------------
`default_nettype none

module tiered_pool_table_round_robin_top #(
  parameter int unsigned TARGET_SLOTS = tptrr_pkg::DEF_TARGET_SLOTS,
  parameter int unsigned MAX_PICKS    = tptrr_pkg::DEF_MAX_PICKS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // target_id[7:0], node_id[23:8], pool_kind[25:24], want_count[32:26], zero pad
  input  wire logic [tptrr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // req_type[2:0]
  input  wire logic [tptrr_pkg::REQ_W-1:0]        s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // changed[0], found[1], pool_of_target[3:2], chosen_target[11:4], zero pad
  output logic [tptrr_pkg::M_TDATA_W-1:0]         m_axis_tdata,
  // chosen_valid
  output logic                                    m_axis_tuser,
  output logic                                    m_axis_tlast
);

  localparam int unsigned IDX_W = $clog2(TARGET_SLOTS);

  tptrr_pkg::req_t          req;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [tptrr_pkg::SLOT_W-1:0] rd_word;
  tptrr_pkg::slot_t         rd_slot;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  tptrr_pkg::slot_t         wr_slot;
  logic                     res_push;
  tptrr_pkg::res_t          res;
  logic                     res_free;

  assign req.req_type   = s_axis_tuser;
  assign req.target_id  = s_axis_tdata[7:0];
  assign req.node_id    = s_axis_tdata[23:8];
  assign req.pool_kind  = s_axis_tdata[25:24];
  assign req.want_count = s_axis_tdata[32:26];

  assign rd_slot = rd_word;

  tptrr_ram #(
    .WIDTH (tptrr_pkg::SLOT_W),
    .DEPTH (TARGET_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_slot),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_word)
  );

  tptrr_ctrl #(
    .TARGET_SLOTS (TARGET_SLOTS),
    .MAX_PICKS    (MAX_PICKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_slot),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_slot),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  tptrr_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (res_push),
    .res_i         (res),
    .free_o        (res_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: tb/sv/tiered_pool_table_round_robin_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tiered_pool_table_round_robin_top_tb
// Drives table updates, pool queries and round-robin choose requests into the
// pool table over its request stream. A software copy of the slot table
// predicts every response, and each response is checked field by field in
// order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tiered_pool_table_round_robin_top_tb;

  localparam int unsigned SLOTS       = tptrr_pkg::DEF_TARGET_SLOTS;
  localparam int unsigned PICK_CAP    = tptrr_pkg::DEF_MAX_PICKS;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned DRAIN_WAIT  = 32;
  localparam int unsigned PRINT_CAP   = 100;

  // request codes the block does not decode
  localparam logic [tptrr_pkg::REQ_W-1:0] REQ_RSVD5 = 3'd5;
  localparam logic [tptrr_pkg::REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [tptrr_pkg::REQ_W-1:0] REQ_RSVD7 = 3'd7;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tptrr_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [tptrr_pkg::REQ_W-1:0]     s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tptrr_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;

  tiered_pool_table_round_robin_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // shadow copy of the slot table
  logic [tptrr_pkg::POOL_W-1:0] slot_pool [SLOTS];
  logic [tptrr_pkg::NODE_W-1:0] slot_node [SLOTS];
  int unsigned                  tier_size [3];
  int unsigned                  rr_cursor;

  tptrr_pkg::res_t pending_responses [$];
  int unsigned error_count     = 0;
  int unsigned requests_sent   = 0;
  int unsigned responses_seen  = 0;
  int unsigned picks_seen      = 0;
  int unsigned choose_requests = 0;
  int unsigned cycle_count     = 0;
  bit          src_gaps_on     = 1'b1;
  bit          sink_stalls_on  = 1'b1;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                 pending_responses.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // mostly short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    begin
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 3);
      if (r < 9) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    begin
      error_count++;
      if (error_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want_v,
                               input int unsigned got_v, input int unsigned idx);
    begin
      if (want_v != got_v)
        flag_mismatch($sformatf("response %0d %s: expected %0d, got %0d", idx, name,
                                want_v, got_v));
    end
  endtask

  // appends one expected response at the tail of the queue
  task automatic queue_expected(input tptrr_pkg::res_t r);
    begin
      pending_responses.insert(pending_responses.size(), r);
    end
  endtask

  // advances the shadow table and queues the responses one request causes
  task automatic predict_response(input logic [tptrr_pkg::REQ_W-1:0] kind,
                                  input logic [tptrr_pkg::TARGET_W-1:0] tgt,
                                  input logic [tptrr_pkg::NODE_W-1:0] node,
                                  input logic [tptrr_pkg::POOL_W-1:0] pk_in,
                                  input logic [tptrr_pkg::PICK_W-1:0] want);
    tptrr_pkg::res_t              r;
    logic [tptrr_pkg::POOL_W-1:0] pk, cur, dest, tier;
    int unsigned                  n, pos, s, i, k;
    bit                           hit;
    begin
      r      = '0;
      r.last = 1'b1;
      pk     = (pk_in == tptrr_pkg::POOL_NONE) ? tptrr_pkg::POOL_EMERG : pk_in;
      case (kind)
        tptrr_pkg::REQ_ADD_UPDATE, tptrr_pkg::REQ_ADD_ABSENT: begin
          cur  = slot_pool[tgt];
          dest = pk;
          if (kind == tptrr_pkg::REQ_ADD_ABSENT && cur != tptrr_pkg::POOL_NONE) dest = cur;
          r.changed = !(cur == dest && slot_node[tgt] == node);
          if (cur != dest) begin
            if (cur != tptrr_pkg::POOL_NONE && tier_size[cur] > 0) tier_size[cur]--;
            tier_size[dest]++;
          end
          slot_pool[tgt] = dest;
          slot_node[tgt] = node;
          queue_expected(r);
        end
        tptrr_pkg::REQ_REMOVE: begin
          cur = slot_pool[tgt];
          if (cur != tptrr_pkg::POOL_NONE) begin
            if (tier_size[cur] > 0) tier_size[cur]--;
            slot_pool[tgt] = tptrr_pkg::POOL_NONE;
          end
          queue_expected(r);
        end
        tptrr_pkg::REQ_QUERY: begin
          if (slot_pool[tgt] != tptrr_pkg::POOL_NONE) begin
            r.found          = 1'b1;
            r.pool_of_target = slot_pool[tgt];
          end else begin
            r.pool_of_target = tptrr_pkg::POOL_EMERG;
          end
          queue_expected(r);
        end
        tptrr_pkg::REQ_CHOOSE: begin
          if (tier_size[tptrr_pkg::POOL_NORMAL] > 0)     tier = tptrr_pkg::POOL_NORMAL;
          else if (tier_size[tptrr_pkg::POOL_LOW] > 0)   tier = tptrr_pkg::POOL_LOW;
          else if (tier_size[tptrr_pkg::POOL_EMERG] > 0) tier = tptrr_pkg::POOL_EMERG;
          else                                           tier = tptrr_pkg::POOL_NONE;
          if (tier == tptrr_pkg::POOL_NONE) begin
            queue_expected(r);
          end else begin
            n = 32'(want);
            if (n > tier_size[tier]) n = tier_size[tier];
            if (n > PICK_CAP) n = PICK_CAP;
            // start: first member at or above the cursor, else the lowest member
            hit = 1'b0;
            pos = 0;
            for (s = rr_cursor; s < SLOTS && !hit; s++)
              if (slot_pool[s] == tier) begin
                pos = s;
                hit = 1'b1;
              end
            for (s = 0; s < SLOTS && !hit; s++)
              if (slot_pool[s] == tier) begin
                pos = s;
                hit = 1'b1;
              end
            for (i = 0; i < n; i++) begin
              hit = 1'b0;
              for (k = 1; k <= SLOTS && !hit; k++)
                if (slot_pool[(pos + k) % SLOTS] == tier) begin
                  pos = (pos + k) % SLOTS;
                  hit = 1'b1;
                end
              r               = '0;
              r.chosen_target = pos[tptrr_pkg::TARGET_W-1:0];
              r.chosen_valid  = 1'b1;
              r.last          = (i + 1 == n);
              queue_expected(r);
            end
            rr_cursor = pos;
            if (n == 0) queue_expected(r);
          end
        end
        default: queue_expected(r);
      endcase
    end
  endtask

  // leaves tvalid high on return so back-to-back requests need no re-raise
  task automatic issue_request(input logic [tptrr_pkg::REQ_W-1:0] kind,
                               input logic [tptrr_pkg::TARGET_W-1:0] tgt,
                               input logic [tptrr_pkg::NODE_W-1:0] node,
                               input logic [tptrr_pkg::POOL_W-1:0] pk,
                               input logic [tptrr_pkg::PICK_W-1:0] want);
    int unsigned idle;
    begin
      idle = (src_gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (idle > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= kind;
      s_axis_tdata  <= {7'b0, want, pk, node, tgt};
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      if (kind == tptrr_pkg::REQ_CHOOSE) choose_requests++;
      requests_sent++;
      predict_response(kind, tgt, node, pk, want);
    end
  endtask

  task automatic release_source();
    begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // response sink: random stalls of varied length
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // response checker
  initial begin
    tptrr_pkg::res_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        responses_seen++;
        if (pending_responses.size() == 0) begin
          flag_mismatch($sformatf("response %0d with no request pending", responses_seen));
        end else begin
          exp_r = pending_responses.pop_front();
          if (exp_r.chosen_valid) picks_seen++;
          compare_field("changed", 32'(exp_r.changed), 32'(m_axis_tdata[0]),
                        responses_seen);
          compare_field("found", 32'(exp_r.found), 32'(m_axis_tdata[1]), responses_seen);
          compare_field("pool_of_target", 32'(exp_r.pool_of_target),
                        32'(m_axis_tdata[3:2]), responses_seen);
          compare_field("chosen_target", 32'(exp_r.chosen_target),
                        32'(m_axis_tdata[11:4]), responses_seen);
          compare_field("chosen_valid", 32'(exp_r.chosen_valid), 32'(m_axis_tuser),
                        responses_seen);
          compare_field("last", 32'(exp_r.last), 32'(m_axis_tlast), responses_seen);
        end
      end
    end
  end

  function automatic logic [tptrr_pkg::REQ_W-1:0] random_kind();
    int unsigned r;
    begin
      r = $urandom_range(0, 99);
      if (r < 30) return tptrr_pkg::REQ_ADD_UPDATE;
      if (r < 45) return tptrr_pkg::REQ_ADD_ABSENT;
      if (r < 63) return tptrr_pkg::REQ_REMOVE;
      if (r < 79) return tptrr_pkg::REQ_QUERY;
      if (r < 97) return tptrr_pkg::REQ_CHOOSE;
      case ($urandom_range(0, 2))
        0:       return REQ_RSVD5;
        1:       return REQ_RSVD6;
        default: return REQ_RSVD7;
      endcase
    end
  endfunction

  function automatic logic [tptrr_pkg::PICK_W-1:0] random_want();
    int unsigned r;
    begin
      r = $urandom_range(0, 19);
      if (r < 14) return tptrr_pkg::PICK_W'($urandom_range(0, 6));
      if (r < 19) return tptrr_pkg::PICK_W'($urandom_range(7, 20));
      return tptrr_pkg::PICK_W'($urandom_range(21, 127));
    end
  endfunction

  // choose on an empty table, misses, and undecoded request codes
  task automatic test_empty_table();
    begin
      issue_request(tptrr_pkg::REQ_CHOOSE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_CHOOSE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd127);
      issue_request(tptrr_pkg::REQ_QUERY, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_REMOVE, 8'd5, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(REQ_RSVD5, 8'hff, 16'hffff, tptrr_pkg::POOL_NONE, 7'h7f);
      issue_request(REQ_RSVD6, 8'h00, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(REQ_RSVD7, 8'haa, 16'h5555, tptrr_pkg::POOL_LOW, 7'd64);
    end
  endtask

  task automatic test_table_updates();
    begin
      issue_request(tptrr_pkg::REQ_ADD_UPDATE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_ADD_UPDATE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_ADD_UPDATE, 8'd0, 16'h0000, tptrr_pkg::POOL_LOW, 7'd0);
      // already pooled: keeps low, same node
      issue_request(tptrr_pkg::REQ_ADD_ABSENT, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_ADD_ABSENT, 8'd0, 16'hffff, tptrr_pkg::POOL_NORMAL, 7'd0);
      // pool code three lands in emergency
      issue_request(tptrr_pkg::REQ_ADD_ABSENT, 8'd255, 16'hffff, tptrr_pkg::POOL_NONE, 7'd0);
      issue_request(tptrr_pkg::REQ_QUERY, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_QUERY, 8'd255, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_ADD_UPDATE, 8'd128, 16'h8000, tptrr_pkg::POOL_NONE, 7'd0);
      issue_request(tptrr_pkg::REQ_REMOVE, 8'd128, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_QUERY, 8'd128, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      // re-add after the remove, with the node the slot had before
      issue_request(tptrr_pkg::REQ_ADD_UPDATE, 8'd128, 16'h8000, tptrr_pkg::POOL_NORMAL,
                    7'd0);
    end
  endtask

  task automatic test_tier_order();
    begin
      issue_request(tptrr_pkg::REQ_ADD_UPDATE, 8'd3, 16'h1234, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_CHOOSE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd127);
      issue_request(tptrr_pkg::REQ_CHOOSE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_REMOVE, 8'd3, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_REMOVE, 8'd128, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_CHOOSE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd2);
      issue_request(tptrr_pkg::REQ_REMOVE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd0);
      issue_request(tptrr_pkg::REQ_CHOOSE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd3);
    end
  endtask

  // targets mostly from a small range so tiers fill and drain often
  task automatic test_random_mix(input int unsigned count);
    logic [tptrr_pkg::TARGET_W-1:0] tgt;
    int unsigned                    i;
    begin
      for (i = 0; i < count; i++) begin
        src_gaps_on    = !(i >= count / 3 && i < count / 3 + 20);
        sink_stalls_on = src_gaps_on;
        tgt = ($urandom_range(0, 4) == 0) ? tptrr_pkg::TARGET_W'($urandom_range(0, 255))
                                          : tptrr_pkg::TARGET_W'($urandom_range(0, 15));
        issue_request(random_kind(), tgt, tptrr_pkg::NODE_W'($urandom_range(0, 16'hffff)),
                      tptrr_pkg::POOL_W'($urandom_range(0, 3)), random_want());
      end
      src_gaps_on    = 1'b1;
      sink_stalls_on = 1'b1;
    end
  endtask

  // a normal pool larger than the pick cap
  task automatic test_pick_cap(input int unsigned adds);
    int unsigned i, base;
    begin
      base = $urandom_range(0, 255);
      for (i = 0; i < adds; i++)
        issue_request(tptrr_pkg::REQ_ADD_UPDATE, tptrr_pkg::TARGET_W'((base + i * 3) % SLOTS),
                      tptrr_pkg::NODE_W'($urandom_range(0, 16'hffff)),
                      tptrr_pkg::POOL_NORMAL, tptrr_pkg::PICK_W'($urandom_range(0, 127)));
      issue_request(tptrr_pkg::REQ_CHOOSE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd64);
      issue_request(tptrr_pkg::REQ_CHOOSE, 8'd0, 16'h0000, tptrr_pkg::POOL_NORMAL, 7'd127);
      issue_request(tptrr_pkg::REQ_CHOOSE, tptrr_pkg::TARGET_W'($urandom_range(0, 255)),
                    tptrr_pkg::NODE_W'($urandom_range(0, 16'hffff)),
                    tptrr_pkg::POOL_W'($urandom_range(0, 3)),
                    tptrr_pkg::PICK_W'($urandom_range(30, 127)));
    end
  endtask

  initial begin
    int unsigned s;
    for (s = 0; s < SLOTS; s++) begin
      slot_pool[s] = tptrr_pkg::POOL_NONE;
      slot_node[s] = '0;
    end
    tier_size[0] = 0;
    tier_size[1] = 0;
    tier_size[2] = 0;
    rr_cursor    = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_table_updates();
    test_tier_order();
    test_random_mix(52);
    test_pick_cap(68);
    release_source();

    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d requests (%0d choose) and %0d responses, %0d of them picks",
             requests_sent, choose_requests, responses_seen, picks_seen);
    $display("tiers exercised: normal, low and emergency, with capped and empty chooses");
    if (error_count == 0 && pending_responses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d responses missing", error_count,
               pending_responses.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
